[sv/dma_pkg.sv]
// Shared types and constants for the dual moving-average meter.
// No dependencies; every other file in sv/ refers to it by scoped names.
package dma_pkg;

    localparam int GAIN_BITS      = 11;
    localparam int OFFSET_BITS    = 8;
    localparam int VALUE_BITS     = 14;
    localparam int DIGIT_BITS     = 4;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 11;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = 14'd16383;
    localparam logic [DIGIT_BITS-1:0] DIGIT_MAX = 4'd9;

    // x / 1000 == (x * DIV_MUL) >> DIV_SHIFT, exact for x < 2^32
    localparam int                    DIV_MUL_BITS = 29;
    localparam int                    DIV_SHIFT    = 38;
    localparam logic [DIV_MUL_BITS-1:0] DIV_MUL    = 29'd274877907;

    // Reciprocals for the decimal split, exact for 14-bit values
    localparam logic [16:0] THOU_MUL   = 17'd16778;
    localparam int          THOU_SHIFT = 24;
    localparam int          THOU_BITS  = 5;
    localparam logic [16:0] HUND_MUL   = 17'd10486;
    localparam int          HUND_SHIFT = 20;
    localparam int          HUND_BITS  = 8;
    localparam logic [16:0] TENS_MUL   = 17'd52429;
    localparam int          TENS_SHIFT = 19;
    localparam int          TENS_BITS  = 11;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_VOLT_GAIN   = 2'd0,
        REG_CURR_GAIN   = 2'd1,
        REG_CURR_OFFSET = 2'd2
    } cfg_reg_t;

    localparam logic [GAIN_BITS-1:0]   VOLT_GAIN_RESET   = 11'd1629;
    localparam logic [GAIN_BITS-1:0]   CURR_GAIN_RESET   = 11'd803;
    localparam logic [OFFSET_BITS-1:0] CURR_OFFSET_RESET = 8'd22;

    typedef struct packed {
        logic advance;
        logic fire;
    } ctrl_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [DIGIT_BITS-1:0] thousands;
        logic [DIGIT_BITS-1:0] hundreds;
        logic [DIGIT_BITS-1:0] tens;
        logic [DIGIT_BITS-1:0] ones;
    } lane_res_t;

endpackage

[sv/dma_if.sv]
// Valid/ready channel interfaces for the meter's sample input and result output.
// Depends on dma_pkg for the result field widths.
interface dma_in_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] volt_sample;
    logic [SAMPLE_BITS-1:0] curr_sample;

    modport source (output valid, volt_sample, curr_sample, input ready);
    modport sink   (input valid, volt_sample, curr_sample, output ready);
endinterface

interface dma_out_if;
    logic                            valid;
    logic                            ready;
    logic [dma_pkg::VALUE_BITS-1:0]  volt_value;
    logic [dma_pkg::DIGIT_BITS-1:0]  volt_thousands;
    logic [dma_pkg::DIGIT_BITS-1:0]  volt_hundreds;
    logic [dma_pkg::DIGIT_BITS-1:0]  volt_tens;
    logic [dma_pkg::DIGIT_BITS-1:0]  volt_ones;
    logic [dma_pkg::VALUE_BITS-1:0]  curr_value;
    logic [dma_pkg::DIGIT_BITS-1:0]  curr_thousands;
    logic [dma_pkg::DIGIT_BITS-1:0]  curr_hundreds;
    logic [dma_pkg::DIGIT_BITS-1:0]  curr_tens;
    logic [dma_pkg::DIGIT_BITS-1:0]  curr_ones;

    modport source (
        output valid, volt_value, volt_thousands, volt_hundreds, volt_tens, volt_ones,
        output curr_value, curr_thousands, curr_hundreds, curr_tens, curr_ones,
        input  ready
    );
    modport sink (
        input  valid, volt_value, volt_thousands, volt_hundreds, volt_tens, volt_ones,
        input  curr_value, curr_thousands, curr_hundreds, curr_tens, curr_ones,
        output ready
    );
endinterface

[sv/dma_lane.sv]
// One measurement lane: ring buffer, running sum, average, gain, offset and
// decimal split as an eight-stage pipeline. Depends on dma_pkg.
module dma_lane #(
    parameter int WINDOW_DEPTH = 128,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dma_pkg::ctrl_t                      ctrl,
    input  logic [SAMPLE_BITS-1:0]              sample,
    input  logic [dma_pkg::GAIN_BITS-1:0]       gain,
    input  logic [dma_pkg::OFFSET_BITS-1:0]     offset,
    output logic                                last_valid,
    output dma_pkg::lane_res_t                  res
);

    localparam int SLOT_BITS = $clog2(WINDOW_DEPTH);
    localparam int SUM_BITS  = SAMPLE_BITS + SLOT_BITS;
    localparam int AVG_SHIFT = SUM_BITS + SLOT_BITS;
    localparam int AVG_WIDE  = 2 * SUM_BITS + 1;
    localparam longint unsigned AVG_MUL_FULL =
        ((64'd1 << AVG_SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
    localparam logic [SUM_BITS:0] AVG_MUL = AVG_MUL_FULL[SUM_BITS:0];
    localparam int PROD_BITS = SAMPLE_BITS + dma_pkg::GAIN_BITS;
    localparam int QUOT_WIDE = PROD_BITS + dma_pkg::DIV_MUL_BITS;
    localparam int QUOT_BITS = QUOT_WIDE - dma_pkg::DIV_SHIFT;
    localparam int VB        = dma_pkg::VALUE_BITS;
    localparam int STAGES    = 8;
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(WINDOW_DEPTH - 1);

    // control state
    logic [SLOT_BITS-1:0] slot_reg, slot_next;
    logic                 filled_reg, filled_next;
    logic [STAGES-1:0]    valid_reg, valid_next;
    logic [SUM_BITS-1:0]  sum_reg, sum_next;

    // ring buffer
    logic [SAMPLE_BITS-1:0] window_mem [WINDOW_DEPTH];
    logic [SAMPLE_BITS-1:0] old_reg;

    // pipeline payload
    logic [SAMPLE_BITS-1:0]         s1_new_reg;
    logic                           s1_filled_reg;
    logic [SUM_BITS-1:0]            s2_sum_reg;
    logic [SAMPLE_BITS-1:0]         s3_avg_reg;
    logic [PROD_BITS-1:0]           s4_prod_reg;
    logic [QUOT_BITS-1:0]           s5_quot_reg;
    logic [VB-1:0]                  s6_val_reg;
    logic [VB-1:0]                  s7_val_reg;
    logic [dma_pkg::THOU_BITS-1:0]  s7_thou_reg;
    logic [dma_pkg::HUND_BITS-1:0]  s7_hund_reg;
    logic [dma_pkg::TENS_BITS-1:0]  s7_tens_reg;
    dma_pkg::lane_res_t             res_reg;

    // combinational stage logic
    logic [SAMPLE_BITS-1:0]         old_val;
    logic [SUM_BITS-1:0]            sum_upd;
    logic [AVG_WIDE-1:0]            avg_wide;
    logic [PROD_BITS-1:0]           prod;
    logic [QUOT_WIDE-1:0]           quot_wide;
    logic [VB-1:0]                  sat_val;
    logic [VB-1:0]                  off_val;
    logic [31:0]                    thou_wide, hund_wide, tens_wide;
    logic [dma_pkg::HUND_BITS-1:0]  hund_rem;
    logic [dma_pkg::TENS_BITS-1:0]  tens_rem;
    logic [VB-1:0]                  ones_rem;
    dma_pkg::lane_res_t             res_new;

    // Read-first: the slot's old sample comes out as the new one goes in.
    always_ff @(posedge clk)
    begin
        if (ctrl.fire)
        begin
            old_reg              <= window_mem[slot_reg];
            window_mem[slot_reg] <= sample;
        end
    end

    always_comb
    begin
        // until the first pass completes, slots not yet written count as zero
        old_val = s1_filled_reg ? old_reg : '0;
        sum_upd = sum_reg + SUM_BITS'(s1_new_reg) - SUM_BITS'(old_val);

        slot_next   = slot_reg;
        filled_next = filled_reg;
        if (ctrl.fire)
        begin
            if (slot_reg == LAST_SLOT)
            begin
                slot_next   = '0;
                filled_next = 1'b1;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end

        valid_next = valid_reg;
        sum_next   = sum_reg;
        if (ctrl.advance)
        begin
            valid_next = {valid_reg[STAGES-2:0], ctrl.fire};
            if (valid_reg[0])
            begin
                sum_next = sum_upd;
            end
        end
    end

    always_comb
    begin
        avg_wide  = AVG_WIDE'(s2_sum_reg) * AVG_WIDE'(AVG_MUL);
        prod      = PROD_BITS'(s3_avg_reg) * PROD_BITS'(gain);
        quot_wide = QUOT_WIDE'(s4_prod_reg) * QUOT_WIDE'(dma_pkg::DIV_MUL);

        if (32'(s5_quot_reg) > 32'(dma_pkg::VALUE_MAX))
        begin
            sat_val = dma_pkg::VALUE_MAX;
        end
        else
        begin
            sat_val = VB'(s5_quot_reg);
        end
        off_val = (sat_val > VB'(offset)) ? sat_val - VB'(offset) : '0;

        thou_wide = 32'(s6_val_reg) * 32'(dma_pkg::THOU_MUL);
        hund_wide = 32'(s6_val_reg) * 32'(dma_pkg::HUND_MUL);
        tens_wide = 32'(s6_val_reg) * 32'(dma_pkg::TENS_MUL);

        hund_rem = s7_hund_reg - dma_pkg::HUND_BITS'(s7_thou_reg) * 8'd10;
        tens_rem = s7_tens_reg - dma_pkg::TENS_BITS'(s7_hund_reg) * 11'd10;
        ones_rem = s7_val_reg - VB'(s7_tens_reg) * 14'd10;

        res_new.value     = s7_val_reg;
        // value tops out at 16383, so the thousands count stays below 20
        res_new.thousands = (s7_thou_reg >= 5'd10)
                            ? dma_pkg::DIGIT_BITS'(s7_thou_reg - 5'd10)
                            : dma_pkg::DIGIT_BITS'(s7_thou_reg);
        res_new.hundreds  = dma_pkg::DIGIT_BITS'(hund_rem);
        res_new.tens      = dma_pkg::DIGIT_BITS'(tens_rem);
        res_new.ones      = dma_pkg::DIGIT_BITS'(ones_rem);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg   <= '0;
            filled_reg <= 1'b0;
            valid_reg  <= '0;
            sum_reg    <= '0;
        end
        else
        begin
            slot_reg   <= slot_next;
            filled_reg <= filled_next;
            valid_reg  <= valid_next;
            sum_reg    <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            s1_new_reg    <= sample;
            s1_filled_reg <= filled_reg;
            s2_sum_reg    <= sum_upd;
            s3_avg_reg    <= avg_wide[AVG_SHIFT +: SAMPLE_BITS];
            s4_prod_reg   <= prod;
            s5_quot_reg   <= quot_wide[dma_pkg::DIV_SHIFT +: QUOT_BITS];
            s6_val_reg    <= off_val;
            s7_val_reg    <= s6_val_reg;
            s7_thou_reg   <= thou_wide[dma_pkg::THOU_SHIFT +: dma_pkg::THOU_BITS];
            s7_hund_reg   <= hund_wide[dma_pkg::HUND_SHIFT +: dma_pkg::HUND_BITS];
            s7_tens_reg   <= tens_wide[dma_pkg::TENS_SHIFT +: dma_pkg::TENS_BITS];
            res_reg       <= res_new;
        end
    end

    assign last_valid = valid_reg[STAGES-1];
    assign res        = res_reg;

`ifndef SYNTHESIS
    a_filled_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg |=> filled_reg)
        else $error("ring buffer fill flag dropped");

    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.fire && slot_reg == LAST_SLOT |=> filled_reg && slot_reg == '0)
        else $error("write slot did not wrap into a full window");

    a_digits: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[STAGES-1] |-> res_reg.thousands <= dma_pkg::DIGIT_MAX
            && res_reg.hundreds <= dma_pkg::DIGIT_MAX
            && res_reg.tens <= dma_pkg::DIGIT_MAX
            && res_reg.ones <= dma_pkg::DIGIT_MAX)
        else $error("decimal digit out of range");
`endif

endmodule

[sv/dma_merge.sv]
// Pipeline control and result merge: joins both lanes into one result
// transaction behind an output register and a skid stage. Depends on dma_pkg, dma_if.
module dma_merge (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               last_valid,
    input  dma_pkg::lane_res_t volt_res,
    input  dma_pkg::lane_res_t curr_res,
    output dma_pkg::ctrl_t     ctrl,
    dma_out_if.source          out_ch
);

    typedef struct packed {
        dma_pkg::lane_res_t volt;
        dma_pkg::lane_res_t curr;
    } item_t;

    logic  out_valid_reg, out_valid_next;
    logic  skid_valid_reg, skid_valid_next;
    item_t out_item_reg, out_item_next;
    item_t skid_item_reg, skid_item_next;
    item_t new_item;
    logic  incoming;
    logic  out_free;

    always_comb
    begin
        ctrl.advance = !skid_valid_reg;
        ctrl.fire    = in_valid && ctrl.advance;
        incoming     = last_valid && ctrl.advance;
        out_free     = !out_valid_reg || out_ch.ready;

        new_item.volt = volt_res;
        new_item.curr = curr_res;

        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        skid_valid_next = skid_valid_reg;
        skid_item_next  = skid_item_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = incoming;
                out_item_next  = new_item;
            end
        end
        else if (incoming)
        begin
            skid_valid_next = 1'b1;
            skid_item_next  = new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.volt_value     = out_item_reg.volt.value;
    assign out_ch.volt_thousands = out_item_reg.volt.thousands;
    assign out_ch.volt_hundreds  = out_item_reg.volt.hundreds;
    assign out_ch.volt_tens      = out_item_reg.volt.tens;
    assign out_ch.volt_ones      = out_item_reg.volt.ones;
    assign out_ch.curr_value     = out_item_reg.curr.value;
    assign out_ch.curr_thousands = out_item_reg.curr.thousands;
    assign out_ch.curr_hundreds  = out_item_reg.curr.hundreds;
    assign out_ch.curr_tens      = out_item_reg.curr.tens;
    assign out_ch.curr_ones      = out_item_reg.curr.ones;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while the output register is empty");

    a_skid_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ch.ready))
        else $error("skid stage filled without an output stall");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready && !skid_valid_reg && last_valid |=> skid_valid_reg)
        else $error("result leaving the pipeline was not captured");
`endif

endmodule

[sv/dual_moving_average_meter.sv]
// Dual moving-average meter: one 2-lane pipeline (voltage, current) feeding a result merge.
// Depends on dma_pkg, dma_if, dma_lane, dma_merge.
//
// Each transaction on in_ch carries a voltage and a current ADC code; each produces exactly
// one transaction on out_ch with both scaled moving averages and their decimal digits. The
// block takes one transaction per clock cycle while the skid stage is empty; each result
// passes through the eight lane stages, which hold each lane's chain of average, gain and
// divide-by-1000 multipliers, and then through the output register on its way to out_ch.
// Each lane's ring buffer is a single-port read-first memory, written and read once per
// accepted sample. After reset the window counts as all zero through a fill flag, so there
// is no clearing pass and the block accepts samples from the first cycle. Stalls on out_ch
// are absorbed by a one-entry skid stage before in_ch.ready drops. Gain and offset
// registers are to be written only while no result is pending.
module dual_moving_average_meter #(
    parameter int WINDOW_DEPTH = 128,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [dma_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [dma_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    dma_in_if.sink                               in_ch,
    dma_out_if.source                            out_ch
);

    logic [dma_pkg::GAIN_BITS-1:0]   volt_gain_reg, volt_gain_next;
    logic [dma_pkg::GAIN_BITS-1:0]   curr_gain_reg, curr_gain_next;
    logic [dma_pkg::OFFSET_BITS-1:0] curr_offset_reg, curr_offset_next;

    dma_pkg::ctrl_t     ctrl;
    dma_pkg::lane_res_t volt_res;
    dma_pkg::lane_res_t curr_res;
    logic               volt_last_valid;
    logic               curr_last_valid;

    always_comb
    begin
        volt_gain_next   = volt_gain_reg;
        curr_gain_next   = curr_gain_reg;
        curr_offset_next = curr_offset_reg;
        if (cfg_we)
        begin
            unique case (dma_pkg::cfg_reg_t'(cfg_index))
                dma_pkg::REG_VOLT_GAIN:
                    volt_gain_next = cfg_data[dma_pkg::GAIN_BITS-1:0];
                dma_pkg::REG_CURR_GAIN:
                    curr_gain_next = cfg_data[dma_pkg::GAIN_BITS-1:0];
                dma_pkg::REG_CURR_OFFSET:
                    curr_offset_next = cfg_data[dma_pkg::OFFSET_BITS-1:0];
                default:
                begin
                    // unknown index: write ignored
                    volt_gain_next = volt_gain_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_gain_reg   <= dma_pkg::VOLT_GAIN_RESET;
            curr_gain_reg   <= dma_pkg::CURR_GAIN_RESET;
            curr_offset_reg <= dma_pkg::CURR_OFFSET_RESET;
        end
        else
        begin
            volt_gain_reg   <= volt_gain_next;
            curr_gain_reg   <= curr_gain_next;
            curr_offset_reg <= curr_offset_next;
        end
    end

    assign in_ch.ready = ctrl.advance;

    dma_lane #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_volt_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .sample     (in_ch.volt_sample),
        .gain       (volt_gain_reg),
        .offset     ('0),
        .last_valid (volt_last_valid),
        .res        (volt_res)
    );

    dma_lane #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_curr_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .sample     (in_ch.curr_sample),
        .gain       (curr_gain_reg),
        .offset     (curr_offset_reg),
        .last_valid (curr_last_valid),
        .res        (curr_res)
    );

    dma_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .last_valid (volt_last_valid && curr_last_valid),
        .volt_res   (volt_res),
        .curr_res   (curr_res),
        .ctrl       (ctrl),
        .out_ch     (out_ch)
    );

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for dual_moving_average_meter: directed and random ADC pairs in several
// gain/offset settings, each reading predicted locally and compared field by field.
// Depends on dma_pkg, dma_if and the meter RTL.
module tb_top;

    localparam int WINDOW       = 128;
    localparam int SAMPLE_W     = 12;
    localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW);
    localparam int SCALE_DIV    = 1000;
    localparam int IDLE_PCT     = 20;
    localparam int STALL_AT     = 580;
    localparam int STALL_CYCLES = 100;
    localparam int WATCHDOG_MAX = 5000;
    localparam int TAIL_CYCLES  = 12;
    localparam logic [dma_pkg::CFG_INDEX_BITS-1:0] REG_UNMAPPED = 2'd3;

    typedef enum {MIX_UNIFORM, MIX_LOW, MIX_FULL_SCALE, MIX_EXTREMES} code_mix_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] volt;
        logic [SAMPLE_W-1:0] curr;
    } adc_pair_t;

    typedef struct packed {
        dma_pkg::lane_res_t volt;
        dma_pkg::lane_res_t curr;
    } reading_t;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [dma_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [dma_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    dma_in_if #(.SAMPLE_BITS(SAMPLE_W)) in_ch ();
    dma_out_if out_ch ();

    dual_moving_average_meter #(
        .WINDOW_DEPTH (WINDOW),
        .SAMPLE_BITS  (SAMPLE_W)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // local copy of the meter's registers and window state
    logic [dma_pkg::GAIN_BITS-1:0]   volt_gain_q   = dma_pkg::VOLT_GAIN_RESET;
    logic [dma_pkg::GAIN_BITS-1:0]   curr_gain_q   = dma_pkg::CURR_GAIN_RESET;
    logic [dma_pkg::OFFSET_BITS-1:0] curr_offset_q = dma_pkg::CURR_OFFSET_RESET;
    logic [SAMPLE_W-1:0]             volt_history [WINDOW];
    logic [SAMPLE_W-1:0]             curr_history [WINDOW];
    logic [SUM_W-1:0]                volt_sum = '0;
    logic [SUM_W-1:0]                curr_sum = '0;
    int unsigned                     fill_slot = 0;

    adc_pair_t pending_pairs[$];
    reading_t  pending_readings[$];

    int  samples_queued   = 0;
    int  samples_accepted = 0;
    int  readings_checked = 0;
    int  mismatch_count   = 0;
    int  settings_used    = 1;
    int  quiet_cycles     = 0;
    int  sink_count       = 0;
    int  stall_left       = 0;
    bit  long_stall_done  = 1'b0;
    bit  no_idle          = 1'b0;
    bit  sender_hold      = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic dma_pkg::lane_res_t scale_lane(logic [SUM_W-1:0] sum,
                                                      logic [dma_pkg::GAIN_BITS-1:0] gain,
                                                      logic [dma_pkg::OFFSET_BITS-1:0] offset);
        int unsigned        scaled;
        dma_pkg::lane_res_t lane;
        scaled = (32'(sum) / WINDOW) * 32'(gain) / SCALE_DIV;
        if (scaled > dma_pkg::VALUE_MAX)
            scaled = dma_pkg::VALUE_MAX;
        scaled = (scaled > offset) ? scaled - offset : 0;
        lane.value     = scaled[dma_pkg::VALUE_BITS-1:0];
        lane.thousands = dma_pkg::DIGIT_BITS'((scaled / 1000) % 10);
        lane.hundreds  = dma_pkg::DIGIT_BITS'((scaled / 100) % 10);
        lane.tens      = dma_pkg::DIGIT_BITS'((scaled / 10) % 10);
        lane.ones      = dma_pkg::DIGIT_BITS'(scaled % 10);
        return lane;
    endfunction

    // new code replaces the oldest slot; empty slots hold zero during warm-up
    function automatic reading_t advance_window(adc_pair_t pair);
        reading_t reading;
        volt_sum = volt_sum + pair.volt - volt_history[fill_slot];
        curr_sum = curr_sum + pair.curr - curr_history[fill_slot];
        volt_history[fill_slot] = pair.volt;
        curr_history[fill_slot] = pair.curr;
        fill_slot = (fill_slot + 1) % WINDOW;
        reading.volt = scale_lane(volt_sum, volt_gain_q, '0);
        reading.curr = scale_lane(curr_sum, curr_gain_q, curr_offset_q);
        return reading;
    endfunction

    task automatic compare_field(string field, logic [dma_pkg::VALUE_BITS-1:0] want,
                                 logic [dma_pkg::VALUE_BITS-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_lane(string lane, dma_pkg::lane_res_t want, dma_pkg::lane_res_t got);
        compare_field({lane, "_value"}, want.value, got.value);
        compare_field({lane, "_thousands"}, want.thousands, got.thousands);
        compare_field({lane, "_hundreds"}, want.hundreds, got.hundreds);
        compare_field({lane, "_tens"}, want.tens, got.tens);
        compare_field({lane, "_ones"}, want.ones, got.ones);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_code(code_mix_t mix);
        case (mix)
            MIX_LOW:        return SAMPLE_W'($urandom_range(63));
            MIX_FULL_SCALE: return {SAMPLE_W{1'b1}};
            MIX_EXTREMES:
            begin
                case ($urandom_range(3))
                    0:       return '0;
                    1:       return {SAMPLE_W{1'b1}};
                    default: return SAMPLE_W'($urandom_range((1 << SAMPLE_W) - 1));
                endcase
            end
            default:        return SAMPLE_W'($urandom_range((1 << SAMPLE_W) - 1));
        endcase
    endfunction

    task automatic push_pair(logic [SAMPLE_W-1:0] volt, logic [SAMPLE_W-1:0] curr);
        adc_pair_t pair;
        pair.volt = volt;
        pair.curr = curr;
        pending_pairs.push_back(pair);
        samples_queued++;
    endtask

    task automatic queue_pairs(int count, code_mix_t mix);
        for (int n = 0; n < count; n++)
            push_pair(pick_code(mix), pick_code(mix));
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (samples_accepted != samples_queued || pending_readings.size() != 0);
    endtask

    task automatic write_register(logic [dma_pkg::CFG_INDEX_BITS-1:0] index,
                                  logic [dma_pkg::CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            dma_pkg::REG_VOLT_GAIN:   volt_gain_q   = data[dma_pkg::GAIN_BITS-1:0];
            dma_pkg::REG_CURR_GAIN:   curr_gain_q   = data[dma_pkg::GAIN_BITS-1:0];
            dma_pkg::REG_CURR_OFFSET: curr_offset_q = data[dma_pkg::OFFSET_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // input side: next pair goes out once the current transaction is taken
    always @(posedge clk)
    begin : sample_driver
        adc_pair_t next_pair;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (pending_pairs.size() != 0 && !sender_hold
                    && (no_idle || $urandom_range(99) >= IDLE_PCT))
            begin
                next_pair = pending_pairs.pop_front();
                in_ch.valid       <= 1'b1;
                in_ch.volt_sample <= next_pair.volt;
                in_ch.curr_sample <= next_pair.curr;
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // output side: random back-pressure plus one long hold-off to fill the pipeline
    always @(posedge clk)
    begin : reading_sink
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                sink_count++;
            if (!long_stall_done && sink_count >= STALL_AT)
            begin
                stall_left      = STALL_CYCLES;
                long_stall_done = 1'b1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= no_idle || $urandom_range(99) >= IDLE_PCT;
            end
        end
    end

    always @(posedge clk)
    begin : reading_monitor
        reading_t           want;
        dma_pkg::lane_res_t got_volt;
        dma_pkg::lane_res_t got_curr;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                readings_checked++;
                got_volt = {out_ch.volt_value, out_ch.volt_thousands, out_ch.volt_hundreds,
                            out_ch.volt_tens, out_ch.volt_ones};
                got_curr = {out_ch.curr_value, out_ch.curr_thousands, out_ch.curr_hundreds,
                            out_ch.curr_tens, out_ch.curr_ones};
                if (pending_readings.size() == 0)
                begin
                    $error("reading transaction with no sample outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_readings.pop_front();
                    check_lane("volt", want.volt, got_volt);
                    check_lane("curr", want.curr, got_curr);
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                samples_accepted++;
                pending_readings.push_back(advance_window({in_ch.volt_sample,
                                                           in_ch.curr_sample}));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_MAX)
            begin
                $display("timeout: no transaction for %0d cycles", quiet_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = dma_pkg::REG_VOLT_GAIN;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.volt_sample  = '0;
        in_ch.curr_sample  = '0;
        out_ch.ready       = 1'b0;
        for (int i = 0; i < WINDOW; i++)
        begin
            volt_history[i] = '0;
            curr_history[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // warm-up from an empty window at reset gains; small current falls under the offset
        push_pair(12'd0, 12'd0);
        push_pair(12'd4095, 12'd4095);
        push_pair(12'd4095, 12'd0);
        push_pair(12'd0, 12'd4095);
        push_pair(12'hAAA, 12'h555);
        push_pair(12'h555, 12'hAAA);
        push_pair(12'd1, 12'd1);
        push_pair(12'd2048, 12'd2048);
        push_pair(12'd2047, 12'd2047);
        push_pair(12'd1000, 12'd3500);
        push_pair(12'd4095, 12'd4095);
        push_pair(12'd4095, 12'd4095);
        push_pair(12'd0, 12'd0);
        push_pair(12'd4095, 12'd4095);
        wait_idle();

        // unmapped index must be dropped; offset takes only its low bits
        write_register(REG_UNMAPPED, 11'h7FF);
        write_register(dma_pkg::REG_CURR_OFFSET, 11'h7FF);
        settings_used++;
        queue_pairs(150, MIX_UNIFORM);
        wait_idle();

        // full-scale window at maximum gain, no idling on either side
        write_register(dma_pkg::REG_VOLT_GAIN, 11'd2047);
        write_register(dma_pkg::REG_CURR_GAIN, 11'd2047);
        write_register(dma_pkg::REG_CURR_OFFSET, 11'd0);
        settings_used++;
        no_idle = 1'b1;
        queue_pairs(140, MIX_FULL_SCALE);
        wait_idle();
        no_idle = 1'b0;

        write_register(dma_pkg::REG_VOLT_GAIN, 11'd0);
        write_register(dma_pkg::REG_CURR_GAIN, 11'd0);
        write_register(dma_pkg::REG_CURR_OFFSET, 11'd255);
        settings_used++;
        queue_pairs(100, MIX_UNIFORM);
        wait_idle();

        write_register(dma_pkg::REG_VOLT_GAIN, 11'd1);
        write_register(dma_pkg::REG_CURR_GAIN, 11'd1);
        write_register(dma_pkg::REG_CURR_OFFSET, 11'd1);
        settings_used++;
        queue_pairs(150, MIX_LOW);
        wait_idle();

        for (int k = 0; k < 3; k++)
        begin
            write_register(dma_pkg::REG_VOLT_GAIN,
                           dma_pkg::CFG_DATA_BITS'($urandom_range(2047)));
            write_register(dma_pkg::REG_CURR_GAIN,
                           dma_pkg::CFG_DATA_BITS'($urandom_range(2047)));
            write_register(dma_pkg::REG_CURR_OFFSET,
                           dma_pkg::CFG_DATA_BITS'($urandom_range(255)));
            settings_used++;
            queue_pairs(100, MIX_EXTREMES);
            if (k == 1)
            begin
                // sender stops mid-stream until every reading is back
                while (samples_accepted < samples_queued - 50)
                    @(negedge clk);
                sender_hold = 1'b1;
                while (in_ch.valid || pending_readings.size() != 0)
                    @(negedge clk);
                sender_hold = 1'b0;
            end
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(negedge clk);

        $display("%0d ADC pairs over %0d gain/offset settings, %0d readings checked",
                 samples_accepted, settings_used, readings_checked);
        $display("covered warm-up, full-scale window, zero gain, offset floor, stalls");
        if (mismatch_count == 0 && pending_readings.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
